@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the checker files.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

// Next-cycle implication, never disabled (also checks reset behavior).
`define ASSERT_NEXT(label, clk, cond, prop) \
  label: assert property (@(posedge clk) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/utf8d_pkg.sv @@
// Types and constants of the UTF-8 code point decoder.
// No dependencies; used by utf8d_decode and the top level.
package utf8d_pkg;

  localparam int CP_W = 21;
  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

  // Result queue: four entries, a transaction pushes at most two.
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = 2;
  localparam int CNT_W       = 3;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            replaced;
    logic            last_of_item;
    logic            text_done;
  } result_t;

  typedef struct packed {
    logic [1:0]      count;     // results caused by this byte, 0..2
    result_t         res0;
    result_t         res1;
    logic [CP_W-1:0] accum;     // next payload accumulator
    logic [1:0]      expected;  // next continuation count
  } decode_t;

endpackage

@@ hw/rtl/utf8d_decode.sv @@
// Combinational decode of one byte against the pending sequence state.
// Depends on utf8d_pkg.
module utf8d_decode (
  input  logic [utf8d_pkg::CP_W-1:0] accum,
  input  logic [1:0]                 expected,
  input  logic [7:0]                 byte_in,
  input  logic                       end_of_text,
  output utf8d_pkg::decode_t         dec
);

  typedef struct packed {
    logic                       emit;
    logic                       replaced;
    logic [utf8d_pkg::CP_W-1:0] code_point;
    logic [utf8d_pkg::CP_W-1:0] accum;
    logic [1:0]                 expected;
  } lead_t;

  function automatic lead_t lead_decode(input logic [7:0] b);
    lead_t l;
    l = '0;
    if (b[7] == 1'b0) begin
      l.emit       = 1'b1;
      l.code_point = {13'd0, b};
    end else if (b[7:5] == 3'b110) begin
      l.accum    = {16'd0, b[4:0]};
      l.expected = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      l.accum    = {17'd0, b[3:0]};
      l.expected = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      l.accum    = {18'd0, b[2:0]};
      l.expected = 2'd3;
    end else begin
      // stray continuation or 0xF8..0xFF
      l.emit       = 1'b1;
      l.replaced   = 1'b1;
      l.code_point = utf8d_pkg::REPLACEMENT_CP;
    end
    return l;
  endfunction

  lead_t                       lead;
  utf8d_pkg::result_t          r [2];
  logic [1:0]                  n;
  logic [utf8d_pkg::CP_W-1:0]  acc;
  logic [utf8d_pkg::CP_W-1:0]  shifted;
  logic [1:0]                  exp_cnt;
  logic                        last_idx;

  assign shifted = {accum[utf8d_pkg::CP_W-7:0], byte_in[5:0]};

  always_comb begin
    lead    = lead_decode(byte_in);
    r[0]    = '0;
    r[1]    = '0;
    n       = 2'd0;
    acc     = accum;
    exp_cnt = expected;

    if (expected != 2'd0 && byte_in[7:6] == 2'b10) begin
      acc     = shifted;
      exp_cnt = expected - 2'd1;
      if (exp_cnt == 2'd0) begin
        r[0].code_point = shifted;
        n               = 2'd1;
        acc             = '0;
      end
    end else begin
      // no sequence pending, or a broken one: replace if one was pending, then decode the same byte as a lead
      if (expected != 2'd0) begin
        r[0].code_point = utf8d_pkg::REPLACEMENT_CP;
        r[0].replaced   = 1'b1;
        n               = 2'd1;
      end
      acc     = lead.accum;
      exp_cnt = lead.expected;
      if (lead.emit) begin
        r[n[0]].code_point = lead.code_point;
        r[n[0]].replaced   = lead.replaced;
        n                  = n + 2'd1;
      end
    end

    if (end_of_text) begin
      // truncated sequence at end of string
      if (exp_cnt != 2'd0) begin
        r[n[0]].code_point = utf8d_pkg::REPLACEMENT_CP;
        r[n[0]].replaced   = 1'b1;
        n                  = n + 2'd1;
      end
      acc     = '0;
      exp_cnt = 2'd0;
    end

    last_idx = (n == 2'd2);
    if (n != 2'd0) begin
      r[last_idx].last_of_item = 1'b1;
      r[last_idx].text_done    = end_of_text;
    end

    dec.count    = n;
    dec.res0     = r[0];
    dec.res1     = r[1];
    dec.accum    = acc;
    dec.expected = exp_cnt;
  end

endmodule

@@ hw/rtl/utf8_codepoint_decoder.sv @@
// UTF-8 code point decoder, top level: state registers and result queue.
// Depends on utf8d_pkg and utf8d_decode.
//
//   channel   dir  tdata                  tuser                      tlast
//   s_*       in   [7:0] byte_in          -                          end_of_text
//   m_*       out  [20:0] code_point      [0] replaced,              text_done
//                  [23:21] zero           [1] last_of_item
//
// One byte is accepted per cycle while s_tready is high. Decode is a single pass
// of combinational logic from s_tdata and the sequence state into a 4-entry
// result queue, which registers each result when its byte is accepted and offers
// it on m_*. A byte causing two results holds the output for both, so
// the sustained rate is one byte per cycle while bytes give at most one result.
// s_tready depends only on the queue fill count (room for two results).
// rst (synchronous) clears the sequence state and empties the queue.
module utf8_codepoint_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
  output logic [1:0]  m_tuser,   // [0] replaced, [1] last_of_item
  output logic        m_tlast    // text_done
);

  // sequence state
  logic [utf8d_pkg::CP_W-1:0]  accum;
  logic [1:0]                  expected;

  // result queue
  utf8d_pkg::result_t          queue [utf8d_pkg::QUEUE_DEPTH];
  logic [utf8d_pkg::PTR_W-1:0] wr_ptr;
  logic [utf8d_pkg::PTR_W-1:0] rd_ptr;
  logic [utf8d_pkg::CNT_W-1:0] count;
  logic [utf8d_pkg::CNT_W-1:0] count_next;

  utf8d_pkg::decode_t          dec;
  utf8d_pkg::result_t          head;
  logic                        accept;
  logic                        pop;
  logic [1:0]                  push;

  utf8d_decode u_decode (
    .accum       (accum),
    .expected    (expected),
    .byte_in     (s_tdata),
    .end_of_text (s_tlast),
    .dec         (dec)
  );

  // Room for the worst case of two results per transaction.
  assign s_tready = (count < utf8d_pkg::CNT_W'(utf8d_pkg::QUEUE_DEPTH - 1));
  assign accept   = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;
  assign push     = accept ? dec.count : 2'd0;

  assign count_next = count + utf8d_pkg::CNT_W'(push) - utf8d_pkg::CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      accum    <= '0;
      expected <= '0;
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
    end else begin
      if (accept) begin
        accum    <= dec.accum;
        expected <= dec.expected;
      end
      wr_ptr <= wr_ptr + utf8d_pkg::PTR_W'(push);
      if (pop) begin
        rd_ptr <= rd_ptr + utf8d_pkg::PTR_W'(1);
      end
      count <= count_next;
    end
  end

  // Queue payload, no reset needed.
  always_ff @(posedge clk) begin
    if (push != 2'd0) begin
      queue[wr_ptr] <= dec.res0;
    end
    if (push == 2'd2) begin
      queue[wr_ptr + utf8d_pkg::PTR_W'(1)] <= dec.res1;
    end
  end

  assign head     = queue[rd_ptr];
  assign m_tvalid = (count != '0);
  assign m_tdata  = {3'b000, head.code_point};
  assign m_tuser  = {head.last_of_item, head.replaced};
  assign m_tlast  = head.text_done;

endmodule

@@ hw/rtl/utf8d_checker.sv @@
// Port-level checker for utf8_codepoint_decoder, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module utf8d_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // end of string is always the final result of its byte
  `ASSERT_IMPL(a_done_is_last, clk, rst, m_tvalid && m_tlast, m_tuser[1])

  // a replacement always carries U+FFFD
  `ASSERT_IMPL(a_repl_value, clk, rst, m_tvalid && m_tuser[0], m_tdata[20:0] == 21'h00FFFD)

  // padding bits of tdata stay zero
  `ASSERT_IMPL(a_pad_zero, clk, rst, m_tvalid, m_tdata[23:21] == 3'b000)

  // queue is empty after reset
  `ASSERT_NEXT(a_reset_empty, clk, rst, !m_tvalid && s_tready)

  // a stalled result transaction stays offered
  `ASSERT_NEXT(a_out_hold, clk, !rst && m_tvalid && !m_tready, rst || m_tvalid)

endmodule

bind utf8_codepoint_decoder utf8d_checker u_utf8d_checker (.*);
